// ===== design/salc_pkg.sv =====
// salc_pkg: shared constants, types and helpers for the set-associative
// lru tag store. No dependencies; imported by every other design file but salc_tag_ram.
package salc_pkg;

  // default geometry
  localparam int MAX_SET_BITS_DEF = 8;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_WIDTH_DEF   = 64;

  // fixed field widths
  localparam int ADDR_FIELD_W = 64;
  localparam int CNT_W        = 32;
  localparam int STAMP_W      = 32;
  localparam int SET_CFG_W    = 4;
  localparam int WAYS_CFG_W   = 4;
  localparam int BLOCK_CFG_W  = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_PUSH
  } salc_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic mem_rd;
    logic eval;
    logic first_pass;
    logic out_load_now;
    logic out_load_held;
  } salc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic modify;
  } salc_sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

endpackage

// ===== design/salc_if.sv =====
// salc_if: valid/ready channel interfaces for access words and result words.
// Depends on salc_pkg for field widths.
interface salc_in_if import salc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [ADDR_FIELD_W-1:0] address;

  modport source (output valid, output command, output address, input ready);
  modport sink   (input valid, input command, input address, output ready);
endinterface

interface salc_out_if import salc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic             evicted;
  logic [CNT_W-1:0] hits_total;
  logic [CNT_W-1:0] misses_total;
  logic [CNT_W-1:0] evictions_total;

  modport source (output valid, output hit, output evicted, output hits_total,
                  output misses_total, output evictions_total, input ready);
  modport sink   (input valid, input hit, input evicted, input hits_total,
                  input misses_total, input evictions_total, output ready);
endinterface

// ===== design/salc_tag_ram.sv =====
// salc_tag_ram: single write port, single registered read port row memory.
// One row holds all ways of one set. Depends on nothing.
module salc_tag_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 776,
  parameter int AW    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/salc_ctrl.sv =====
// salc_ctrl: sequencer for accept, row read, evaluate/write back and result
// handoff. Depends on salc_pkg for the state enum and command/status structs.
module salc_ctrl import salc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  salc_sts_t sts_i,
  output salc_cmd_t cmd_o
);

  salc_state_e state_q, state_d;
  logic        pass_q, pass_d;
  logic        out_valid_q, out_valid_d;
  logic        last_pass;
  logic        slot_free;

  assign last_pass = !(sts_i.modify && !pass_q);
  assign slot_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_READ;
          pass_d  = 1'b0;
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (!last_pass) begin
          state_d = S_READ;
          pass_d  = 1'b1;
        end else if (slot_free) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      S_READ: begin
        cmd_o.mem_rd = 1'b1;
      end
      S_EVAL: begin
        cmd_o.eval         = 1'b1;
        cmd_o.first_pass   = !pass_q;
        cmd_o.out_load_now = last_pass && slot_free;
      end
      S_PUSH: begin
        cmd_o.out_load_held = slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load_now || cmd_o.out_load_held) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/salc_datapath.sv =====
// salc_datapath: config registers, address split, way compare, lru victim
// tree, row update, counters and result register. Depends on salc_pkg.
module salc_datapath import salc_pkg::*; #(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF,
  parameter int SET_IW       = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  parameter int ROW_W        = MAX_WAYS * (1 + ADDR_WIDTH + STAMP_W)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  salc_cmd_t               cmd_i,
  output salc_sts_t               sts_o,
  input  logic                    command_i,
  input  logic [ADDR_FIELD_W-1:0] address_i,
  output logic                    mem_we_o,
  output logic [SET_IW-1:0]       mem_waddr_o,
  output logic [ROW_W-1:0]        mem_wdata_o,
  output logic                    mem_re_o,
  output logic [SET_IW-1:0]       mem_raddr_o,
  input  logic [ROW_W-1:0]        mem_rdata_i,
  output logic                    hit_o,
  output logic                    evicted_o,
  output logic [CNT_W-1:0]        hits_total_o,
  output logic [CNT_W-1:0]        misses_total_o,
  output logic [CNT_W-1:0]        evictions_total_o
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int LINE_W   = 1 + ADDR_WIDTH + STAMP_W;
  localparam int WAY_IW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int P        = 1 << WAY_IW;
  localparam int NW_W     = ($clog2(MAX_WAYS + 1) > WAYS_CFG_W) ?
                            $clog2(MAX_WAYS + 1) : WAYS_CFG_W;
  localparam int SBC_W    = ($clog2(MAX_SET_BITS + 1) > SET_CFG_W) ?
                            $clog2(MAX_SET_BITS + 1) : SET_CFG_W;
  localparam int SH_W     = ((SBC_W > BLOCK_CFG_W) ? SBC_W : BLOCK_CFG_W) + 1;

  // configuration
  logic [SET_CFG_W-1:0]   set_bits_q;
  logic [WAYS_CFG_W-1:0]  ways_used_q;
  logic [BLOCK_CFG_W-1:0] block_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= '0;
      ways_used_q  <= WAYS_CFG_W'(1);
      block_bits_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SET_BITS:   set_bits_q   <= cfg_data_i[SET_CFG_W-1:0];
        CFG_WAYS_USED:  ways_used_q  <= cfg_data_i[WAYS_CFG_W-1:0];
        CFG_BLOCK_BITS: block_bits_q <= cfg_data_i[BLOCK_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // address split
  logic [SBC_W-1:0]      sb;
  logic [ADDR_WIDTH-1:0] addr_m, off_shift, tag_d;
  logic [SET_IW-1:0]     set_d;
  logic [SH_W-1:0]       tag_sh;

  always_comb begin
    sb        = (SBC_W'(set_bits_q) > SBC_W'(MAX_SET_BITS)) ?
                SBC_W'(MAX_SET_BITS) : SBC_W'(set_bits_q);
    addr_m    = address_i[ADDR_WIDTH-1:0];
    off_shift = addr_m >> block_bits_q;
    set_d     = off_shift[SET_IW-1:0] & ~({SET_IW{1'b1}} << sb);
    tag_sh    = SH_W'(block_bits_q) + SH_W'(sb);
    tag_d     = addr_m >> tag_sh;
  end

  logic [SET_IW-1:0]     set_q;
  logic [ADDR_WIDTH-1:0] tag_q;
  logic                  modify_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      set_q    <= set_d;
      tag_q    <= tag_d;
      modify_q <= command_i;
    end
  end

  assign sts_o.modify = modify_q;

  // rows never written read as all zero
  logic [NUM_SETS-1:0] row_seen_q;
  logic                seen_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_seen_q <= '0;
    end else if (cmd_i.eval) begin
      row_seen_q[set_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) begin
      seen_rd_q <= row_seen_q[set_q];
    end
  end

  assign mem_re_o    = cmd_i.mem_rd;
  assign mem_raddr_o = set_q;

  // way evaluation
  logic [ROW_W-1:0]      row;
  logic [MAX_WAYS-1:0]   lv, rng, match_v, stop_v;
  logic [ADDR_WIDTH-1:0] lt [MAX_WAYS];
  logic [STAMP_W-1:0]    ls [MAX_WAYS];
  logic [NW_W-1:0]       nw;
  logic [WAY_IW-1:0]     sel;
  logic                  found;

  always_comb begin
    row = seen_rd_q ? mem_rdata_i : '0;
    if (ways_used_q == '0) begin
      nw = NW_W'(1);
    end else if (NW_W'(ways_used_q) > NW_W'(MAX_WAYS)) begin
      nw = NW_W'(MAX_WAYS);
    end else begin
      nw = NW_W'(ways_used_q);
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      ls[w]      = row[w*LINE_W +: STAMP_W];
      lt[w]      = row[w*LINE_W + STAMP_W +: ADDR_WIDTH];
      lv[w]      = row[w*LINE_W + STAMP_W + ADDR_WIDTH];
      rng[w]     = NW_W'(w) < nw;
      match_v[w] = rng[w] && lv[w] && (lt[w] == tag_q);
      stop_v[w]  = match_v[w] || (rng[w] && !lv[w]);
    end
    // first way that is a hit or free
    sel   = '0;
    found = 1'b0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (stop_v[w]) begin
        sel   = WAY_IW'(w);
        found = 1'b1;
      end
    end
  end

  // lru victim: tree over ways, lower index wins ties
  logic               node_ok [2*P];
  logic [STAMP_W-1:0] node_st [2*P];
  logic [WAY_IW-1:0]  node_ix [2*P];

  always_comb begin
    for (int i = 0; i < 2*P; i++) begin
      node_ok[i] = 1'b0;
      node_st[i] = '0;
      node_ix[i] = '0;
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      node_ok[P+i] = rng[i];
      node_st[P+i] = ls[i];
      node_ix[P+i] = WAY_IW'(i);
    end
    for (int n = P - 1; n >= 1; n--) begin
      if (node_ok[2*n+1] && (!node_ok[2*n] || node_st[2*n+1] < node_st[2*n])) begin
        node_ok[n] = 1'b1;
        node_st[n] = node_st[2*n+1];
        node_ix[n] = node_ix[2*n+1];
      end else begin
        node_ok[n] = node_ok[2*n];
        node_st[n] = node_st[2*n];
        node_ix[n] = node_ix[2*n];
      end
    end
  end

  logic [WAY_IW-1:0]  way;
  logic               ev_hit, ev_evict;
  logic [STAMP_W-1:0] use_q, use_d;
  logic [CNT_W-1:0]   hits_q, hits_d, miss_q, miss_d, evic_q, evic_d;
  logic [ROW_W-1:0]   new_row;

  always_comb begin
    ev_hit   = found && match_v[sel];
    ev_evict = !found;
    way      = found ? sel : node_ix[1];
    use_d    = use_q + 1'b1;
    hits_d   = ev_hit ? sat_inc(hits_q) : hits_q;
    miss_d   = ev_hit ? miss_q : sat_inc(miss_q);
    evic_d   = ev_evict ? sat_inc(evic_q) : evic_q;
    new_row  = row;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_IW'(w) == way) begin
        new_row[w*LINE_W +: LINE_W] = {1'b1, tag_q, use_d};
      end
    end
  end

  assign mem_we_o    = cmd_i.eval;
  assign mem_waddr_o = set_q;
  assign mem_wdata_o = new_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q  <= '0;
      hits_q <= '0;
      miss_q <= '0;
      evic_q <= '0;
    end else if (cmd_i.eval) begin
      use_q  <= use_d;
      hits_q <= hits_d;
      miss_q <= miss_d;
      evic_q <= evic_d;
    end
  end

  // flags of the first lookup of a word
  logic first_hit_q, first_evict_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && cmd_i.first_pass) begin
      first_hit_q   <= ev_hit;
      first_evict_q <= ev_evict;
    end
  end

  // result register
  logic             out_hit_q, out_evict_q;
  logic [CNT_W-1:0] out_hits_q, out_miss_q, out_evic_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_now) begin
      out_hit_q   <= cmd_i.first_pass ? ev_hit : first_hit_q;
      out_evict_q <= cmd_i.first_pass ? ev_evict : first_evict_q;
      out_hits_q  <= hits_d;
      out_miss_q  <= miss_d;
      out_evic_q  <= evic_d;
    end else if (cmd_i.out_load_held) begin
      out_hit_q   <= first_hit_q;
      out_evict_q <= first_evict_q;
      out_hits_q  <= hits_q;
      out_miss_q  <= miss_q;
      out_evic_q  <= evic_q;
    end
  end

  assign hit_o             = out_hit_q;
  assign evicted_o         = out_evict_q;
  assign hits_total_o      = out_hits_q;
  assign misses_total_o    = out_miss_q;
  assign evictions_total_o = out_evic_q;

endmodule

// ===== design/set_assoc_lru_cache_tags_core.sv =====
// set_assoc_lru_cache_tags_core: top level of the lru tag store.
// Depends on salc_pkg, salc_if, salc_tag_ram, salc_ctrl and salc_datapath.
//
// Usage:
//   in_if carries one access word (command, address); out_if returns one
//   result word per access (hit, evicted and the three running totals).
//   Both are valid/ready; a word moves when valid and ready are high.
//   cfg_we_i/cfg_idx_i/cfg_data_i write set_bits (0), ways_used (1) and
//   block_bits (2); write them only while no access is in flight.
// Timing:
//   one lookup is a row read from the set memory followed by a compare,
//   lru select and row write back; a load/store does one lookup and a
//   modify two, and the result word is registered. One access is in
//   flight at a time, so a new word is accepted only once the controller
//   is back in idle.
// Reset:
//   all lines read as invalid right away (one flop per set marks rows that
//   were ever written), totals and use clock are zero, no sweep is needed.
// Stall:
//   a finished result sits in the output register; the next access is
//   still accepted and runs until its own result must wait for that slot.
module set_assoc_lru_cache_tags_core import salc_pkg::*; #(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  salc_in_if.sink               in_if,
  salc_out_if.source            out_if
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_IW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int ROW_W    = MAX_WAYS * (1 + ADDR_WIDTH + STAMP_W);

  salc_cmd_t         cmd;
  salc_sts_t         sts;
  logic              mem_we, mem_re;
  logic [SET_IW-1:0] mem_waddr, mem_raddr;
  logic [ROW_W-1:0]  mem_wdata, mem_rdata;

  salc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  salc_datapath #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH),
    .SET_IW       (SET_IW),
    .ROW_W        (ROW_W)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .command_i         (in_if.command),
    .address_i         (in_if.address),
    .mem_we_o          (mem_we),
    .mem_waddr_o       (mem_waddr),
    .mem_wdata_o       (mem_wdata),
    .mem_re_o          (mem_re),
    .mem_raddr_o       (mem_raddr),
    .mem_rdata_i       (mem_rdata),
    .hit_o             (out_if.hit),
    .evicted_o         (out_if.evicted),
    .hits_total_o      (out_if.hits_total),
    .misses_total_o    (out_if.misses_total),
    .evictions_total_o (out_if.evictions_total)
  );

  salc_tag_ram #(
    .DEPTH (NUM_SETS),
    .WIDTH (ROW_W),
    .AW    (SET_IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
